[sv/hrv_pkg.sv]
`timescale 1ns / 1ps

package hrv_pkg;

   // Width of the record counter before it saturates.
   localparam int unsigned RECORD_NUMBER_BITS = 16;
   localparam logic [15:0] NUMBER_LIMIT = (RECORD_NUMBER_BITS >= 16) ? 16'hFFFF :
      16'((32'd1 << RECORD_NUMBER_BITS) - 32'd1);

   localparam int unsigned CSR_ADDR_BITS = 3;

   localparam logic [7:0] HIGHEST_TYPE_RESET = 8'd5;
   localparam logic       STOP_AFTER_END_RESET = 1'b1;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] END_RECORD_TYPE = 8'd1;

   // Register indexes, taken from paddr[2].
   localparam logic CSR_HIGHEST_TYPE = 1'b0;
   localparam logic CSR_STOP_AFTER_END = 1'b1;

   // Result status codes.
   localparam logic [2:0] ST_RECORD_OK = 3'd0;
   localparam logic [2:0] ST_BAD_START = 3'd1;
   localparam logic [2:0] ST_BAD_TYPE = 3'd2;
   localparam logic [2:0] ST_CHECKSUM_ERR = 3'd3;
   localparam logic [2:0] ST_FILE_OK = 3'd4;
   localparam logic [2:0] ST_FILE_ERROR = 3'd5;
   localparam logic [2:0] ST_TRUNCATED = 3'd6;

   typedef struct packed {
      logic [7:0] highest_record_type;
      logic       stop_after_end_record;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] record_number;
      logic [15:0] record_address;
      logic [7:0]  record_kind;
      logic [7:0]  data_length;
      logic [7:0]  computed_checksum;
      logic [7:0]  found_checksum;
   } result_type;

endpackage

[sv/hrv_if.sv]
`timescale 1ns / 1ps

interface hrv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_input;

   modport source (output valid, output char_code, output end_of_input, input ready);
   modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

interface hrv_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] record_number;
   logic [15:0] record_address;
   logic [7:0]  record_kind;
   logic [7:0]  data_length;
   logic [7:0]  computed_checksum;
   logic [7:0]  found_checksum;

   modport source (output valid, output status, output record_number,
                   output record_address, output record_kind, output data_length,
                   output computed_checksum, output found_checksum, input ready);
   modport sink (input valid, input status, input record_number,
                 input record_address, input record_kind, input data_length,
                 input computed_checksum, input found_checksum, output ready);
endinterface

[sv/hex_record_verifier.sv]
`timescale 1ns / 1ps

// HEX record verifier: takes a text HEX file one character per beat and
// checks each record (':' start, count, address, type, data, checksum, one
// line-end character), reporting each good record or the first error, and a
// file verdict on an end-of-input beat. It takes one character per clock
// cycle: a beat lands in the input register, and then one pass of the record
// parser updates the record state and, when the character closes a record or
// hits an error, loads the result register. The only hold-up is a character
// that yields a result while the previous result still waits on the response
// side; characters that yield nothing pass it freely. Registers: 0x0 holds the
// highest accepted record type (reset 5), 0x4 bit 0 stops parsing after an end
// record (reset 1); write them only while the block is idle.
module hex_record_verifier (
   input  logic                              clock,
   input  logic                              reset,
   hrv_req_if.sink                           req_bus,
   hrv_rsp_if.source                         rsp_bus,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [hrv_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import hrv_pkg::*;

   cfg_type     cfg_ff;
   logic        csr_write;

   logic        in_valid_ff;
   logic [7:0]  in_char_ff;
   logic        in_eoi_ff;

   logic        out_valid_ff;
   result_type  out_ff;

   logic        gen;
   logic        fire;
   result_type  result;

   // Configuration port: no wait states, register picked by paddr[2].
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      case (paddr[2])
         CSR_HIGHEST_TYPE: prdata = {24'd0, cfg_ff.highest_record_type};
         default: prdata = {31'd0, cfg_ff.stop_after_end_record};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.highest_record_type <= HIGHEST_TYPE_RESET;
         cfg_ff.stop_after_end_record <= STOP_AFTER_END_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            CSR_HIGHEST_TYPE: cfg_ff.highest_record_type <= pwdata[7:0];
            default: cfg_ff.stop_after_end_record <= pwdata[0];
         endcase
      end
   end

   // Advance the held character unless its result would overwrite one that
   // the response side has not yet taken.
   assign fire = in_valid_ff && (!gen || !out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_char_ff <= req_bus.char_code;
         in_eoi_ff <= req_bus.end_of_input;
      end
   end

   hrv_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .item_char (in_char_ff),
      .item_eoi  (in_eoi_ff),
      .fire      (fire),
      .cfg       (cfg_ff),
      .gen       (gen),
      .result    (result)
   );

   // Result register: load on a result-bearing pass, drop once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire && gen) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && gen) begin
         out_ff <= result;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.status = out_ff.status;
   assign rsp_bus.record_number = out_ff.record_number;
   assign rsp_bus.record_address = out_ff.record_address;
   assign rsp_bus.record_kind = out_ff.record_kind;
   assign rsp_bus.data_length = out_ff.data_length;
   assign rsp_bus.computed_checksum = out_ff.computed_checksum;
   assign rsp_bus.found_checksum = out_ff.found_checksum;

endmodule

[sv/hrv_parser.sv]
`timescale 1ns / 1ps

module hrv_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          item_char,
   input  logic                item_eoi,
   input  logic                fire,
   input  hrv_pkg::cfg_type    cfg,
   output logic                gen,
   output hrv_pkg::result_type result
);
   import hrv_pkg::*;

   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_COUNT   = 3'd1,
      PH_ADDR    = 3'd2,
      PH_TYPE    = 3'd3,
      PH_DATA    = 3'd4,
      PH_CSUM    = 3'd5,
      PH_LINEEND = 3'd6
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [8:0]  digits_ff, digits_in;
   logic [3:0]  high_ff, high_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  kind_ff, kind_in;
   logic [15:0] seen_ff, seen_in;
   logic        error_ff, error_in;
   logic        halted_ff, halted_in;

   logic [15:0] next_number;
   logic [3:0]  nibble;
   logic [7:0]  byte_val;
   logic [8:0]  digits_inc;
   logic [7:0]  sum_add;

   function automatic logic [3:0] digit_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
      else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h41 + 8'd10);
      return v;
   endfunction

   always_comb begin
      next_number = (seen_ff >= NUMBER_LIMIT) ? NUMBER_LIMIT : seen_ff + 16'd1;
      nibble = digit_value(item_char);
      byte_val = {high_ff, nibble};
      digits_inc = digits_ff + 9'd1;
      sum_add = sum_ff + byte_val;

      phase_in = phase_ff;
      digits_in = digits_ff;
      high_in = high_ff;
      sum_in = sum_ff;
      count_in = count_ff;
      addr_in = addr_ff;
      kind_in = kind_ff;
      seen_in = seen_ff;
      error_in = error_ff;
      halted_in = halted_ff;

      gen = 1'b0;
      result.status = ST_RECORD_OK;
      result.record_number = next_number;
      result.record_address = addr_ff;
      result.record_kind = kind_ff;
      result.data_length = count_ff;
      result.computed_checksum = 8'(~sum_ff + 8'd1);
      result.found_checksum = 8'd0;

      if (item_eoi) begin
         gen = 1'b1;
         if (error_ff) begin
            result.status = ST_FILE_ERROR;
         end else if (halted_ff || phase_ff == PH_START || phase_ff == PH_LINEEND) begin
            result.status = ST_FILE_OK;
            result.record_number = seen_ff;
         end else begin
            result.status = ST_TRUNCATED;
         end
         phase_in = PH_START;
         digits_in = 9'd0;
         high_in = 4'd0;
         sum_in = 8'd0;
         count_in = 8'd0;
         addr_in = 16'd0;
         kind_in = 8'd0;
         seen_in = 16'd0;
         error_in = 1'b0;
         halted_in = 1'b0;
      end else if (!halted_ff) begin
         case (phase_ff)
            PH_START: begin
               if (item_char != CHAR_COLON) begin
                  gen = 1'b1;
                  result.status = ST_BAD_START;
                  result.record_address = 16'd0;
                  result.record_kind = 8'd0;
                  result.data_length = 8'd0;
                  result.computed_checksum = 8'd0;
                  error_in = 1'b1;
                  halted_in = 1'b1;
               end else begin
                  phase_in = PH_COUNT;
                  digits_in = 9'd0;
                  sum_in = 8'd0;
                  count_in = 8'd0;
                  addr_in = 16'd0;
                  kind_in = 8'd0;
               end
            end
            PH_LINEEND: begin
               phase_in = PH_START;
            end
            default: begin
               digits_in = digits_inc;
               if (!digits_ff[0]) begin
                  high_in = nibble;
               end else begin
                  case (phase_ff)
                     PH_COUNT: begin
                        count_in = byte_val;
                        sum_in = sum_add;
                        phase_in = PH_ADDR;
                        digits_in = 9'd0;
                     end
                     PH_ADDR: begin
                        addr_in = {addr_ff[7:0], byte_val};
                        sum_in = sum_add;
                        if (digits_inc >= 9'd4) begin
                           phase_in = PH_TYPE;
                           digits_in = 9'd0;
                        end
                     end
                     PH_TYPE: begin
                        kind_in = byte_val;
                        sum_in = sum_add;
                        digits_in = 9'd0;
                        if (byte_val > cfg.highest_record_type) begin
                           gen = 1'b1;
                           result.status = ST_BAD_TYPE;
                           result.record_kind = byte_val;
                           result.computed_checksum = 8'(~sum_add + 8'd1);
                           error_in = 1'b1;
                           halted_in = 1'b1;
                        end else begin
                           phase_in = (count_ff == 8'd0) ? PH_CSUM : PH_DATA;
                        end
                     end
                     PH_DATA: begin
                        sum_in = sum_add;
                        if (digits_inc >= {count_ff, 1'b0}) begin
                           phase_in = PH_CSUM;
                           digits_in = 9'd0;
                        end
                     end
                     default: begin
                        digits_in = 9'd0;
                        gen = 1'b1;
                        result.found_checksum = byte_val;
                        if (byte_val != 8'(~sum_ff + 8'd1)) begin
                           result.status = ST_CHECKSUM_ERR;
                           error_in = 1'b1;
                           halted_in = 1'b1;
                        end else begin
                           seen_in = next_number;
                           phase_in = PH_LINEEND;
                           if (kind_ff == END_RECORD_TYPE && cfg.stop_after_end_record) begin
                              halted_in = 1'b1;
                           end
                        end
                     end
                  endcase
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         digits_ff <= 9'd0;
         high_ff <= 4'd0;
         sum_ff <= 8'd0;
         count_ff <= 8'd0;
         addr_ff <= 16'd0;
         kind_ff <= 8'd0;
         seen_ff <= 16'd0;
         error_ff <= 1'b0;
         halted_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         digits_ff <= digits_in;
         high_ff <= high_in;
         sum_ff <= sum_in;
         count_ff <= count_in;
         addr_ff <= addr_in;
         kind_ff <= kind_in;
         seen_ff <= seen_in;
         error_ff <= error_in;
         halted_ff <= halted_in;
      end
   end

endmodule
